### rtl/olids_pkg.sv
// Package for the ordered list block: sizes, field offsets, codes, state
// machine and controller/datapath interface types.
// No dependencies.
package olids_pkg;

   localparam int DEPTH       = 64;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int MODE_W      = 3;
   localparam int POS_W       = 7;
   localparam int STATUS_W    = 2;
   localparam int FOUND_W     = 6;
   localparam int COUNT_OUT_W = 7;
   localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam int REQ_MODE_LSB = 0;
   localparam int REQ_POS_LSB  = REQ_MODE_LSB + MODE_W;
   localparam int REQ_VAL_LSB  = REQ_POS_LSB + POS_W;
   localparam int REQ_KEY_LSB  = REQ_VAL_LSB + DATA_W;
   localparam int REQ_USED_W   = REQ_KEY_LSB + DATA_W;
   localparam int REQ_DATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_FOUND_LSB  = RSP_STATUS_LSB + STATUS_W;
   localparam int RSP_READ_LSB   = RSP_FOUND_LSB + FOUND_W;
   localparam int RSP_COUNT_LSB  = RSP_READ_LSB + DATA_W;
   localparam int RSP_USED_W     = RSP_COUNT_LSB + COUNT_OUT_W;
   localparam int RSP_DATA_W     = ((RSP_USED_W + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR  = 3'd0,
      MODE_INSERT = 3'd1,
      MODE_DELETE = 3'd2,
      MODE_SEARCH = 3'd3,
      MODE_READ   = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_BADPOS   = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_INS_LOOP,
      S_DEL_LOOP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PUT,
      S_SCAN_LOOP,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_COUNT,
      IDX_POS,
      IDX_ZERO,
      IDX_INC,
      IDX_DEC
   } idx_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_CLEAR,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      RA_IDX,
      RA_PREV,
      RA_NEXT
   } raddr_sel_type;

   typedef enum logic {
      WD_SHIFT,
      WD_VALUE
   } wdata_sel_type;

   typedef struct packed {
      logic          load_item;
      idx_op_type    idx_op;
      cnt_op_type    cnt_op;
      raddr_sel_type raddr_sel;
      logic          ram_we;
      wdata_sel_type wdata_sel;
      logic          set_status;
      status_type    status;
      logic          capture_found;
      logic          capture_read;
      logic          push_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     pos_gt_cnt;
      logic     pos_ge_cnt;
      logic     cnt_full;
      logic     idx_gt_pos;
      logic     idx_next_lt_cnt;
      logic     idx_lt_cnt;
      logic     hit;
      logic     rsp_free;
   } dp_stat_type;

endpackage

### rtl/olids_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module olids_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/olids_ctrl.sv
// Controller state machine for the ordered list: sequences shifts, scans
// and result hand-off. Depends on olids_pkg.
module olids_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  olids_pkg::dp_stat_type stat,
   output olids_pkg::ctrl_cmd_type cmd
);

   olids_pkg::state_type state_ff;
   olids_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= olids_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in          = state_ff;
      req_tready        = 1'b0;
      cmd.load_item     = 1'b0;
      cmd.idx_op        = olids_pkg::IDX_HOLD;
      cmd.cnt_op        = olids_pkg::CNT_HOLD;
      cmd.raddr_sel     = olids_pkg::RA_IDX;
      cmd.ram_we        = 1'b0;
      cmd.wdata_sel     = olids_pkg::WD_SHIFT;
      cmd.set_status    = 1'b0;
      cmd.status        = olids_pkg::ST_OK;
      cmd.capture_found = 1'b0;
      cmd.capture_read  = 1'b0;
      cmd.push_rsp      = 1'b0;
      case (state_ff)
         olids_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = olids_pkg::S_DECODE;
            end
         end
         olids_pkg::S_DECODE: begin
            case (stat.mode)
               olids_pkg::MODE_CLEAR: begin
                  cmd.cnt_op = olids_pkg::CNT_CLEAR;
                  state_in   = olids_pkg::S_DONE;
               end
               olids_pkg::MODE_INSERT: begin
                  if (stat.pos_gt_cnt) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = olids_pkg::ST_BADPOS;
                     state_in       = olids_pkg::S_DONE;
                  end else if (stat.cnt_full) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = olids_pkg::ST_FULL;
                     state_in       = olids_pkg::S_DONE;
                  end else begin
                     cmd.idx_op = olids_pkg::IDX_COUNT;
                     state_in   = olids_pkg::S_INS_LOOP;
                  end
               end
               olids_pkg::MODE_DELETE: begin
                  if (stat.pos_ge_cnt) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = olids_pkg::ST_BADPOS;
                     state_in       = olids_pkg::S_DONE;
                  end else begin
                     cmd.idx_op = olids_pkg::IDX_POS;
                     state_in   = olids_pkg::S_DEL_LOOP;
                  end
               end
               olids_pkg::MODE_SEARCH: begin
                  cmd.set_status = 1'b1;
                  cmd.status     = olids_pkg::ST_NOTFOUND;
                  cmd.idx_op     = olids_pkg::IDX_ZERO;
                  state_in       = olids_pkg::S_SCAN_LOOP;
               end
               olids_pkg::MODE_READ: begin
                  if (stat.pos_ge_cnt) begin
                     cmd.set_status = 1'b1;
                     cmd.status     = olids_pkg::ST_BADPOS;
                     state_in       = olids_pkg::S_DONE;
                  end else begin
                     cmd.idx_op = olids_pkg::IDX_POS;
                     state_in   = olids_pkg::S_SCAN_RD;
                  end
               end
               default: begin
                  state_in = olids_pkg::S_DONE;
               end
            endcase
         end
         olids_pkg::S_INS_LOOP: begin
            if (stat.idx_gt_pos) begin
               state_in = olids_pkg::S_SHIFT_RD;
            end else begin
               state_in = olids_pkg::S_PUT;
            end
         end
         olids_pkg::S_DEL_LOOP: begin
            if (stat.idx_next_lt_cnt) begin
               state_in = olids_pkg::S_SHIFT_RD;
            end else begin
               cmd.cnt_op = olids_pkg::CNT_DEC;
               state_in   = olids_pkg::S_DONE;
            end
         end
         olids_pkg::S_SHIFT_RD: begin
            cmd.raddr_sel = (stat.mode == olids_pkg::MODE_INSERT) ?
                            olids_pkg::RA_PREV : olids_pkg::RA_NEXT;
            state_in      = olids_pkg::S_SHIFT_WR;
         end
         olids_pkg::S_SHIFT_WR: begin
            cmd.ram_we    = 1'b1;
            cmd.wdata_sel = olids_pkg::WD_SHIFT;
            if (stat.mode == olids_pkg::MODE_INSERT) begin
               cmd.idx_op = olids_pkg::IDX_DEC;
               state_in   = olids_pkg::S_INS_LOOP;
            end else begin
               cmd.idx_op = olids_pkg::IDX_INC;
               state_in   = olids_pkg::S_DEL_LOOP;
            end
         end
         olids_pkg::S_PUT: begin
            cmd.ram_we    = 1'b1;
            cmd.wdata_sel = olids_pkg::WD_VALUE;
            cmd.cnt_op    = olids_pkg::CNT_INC;
            state_in      = olids_pkg::S_DONE;
         end
         olids_pkg::S_SCAN_LOOP: begin
            if (stat.idx_lt_cnt) begin
               state_in = olids_pkg::S_SCAN_RD;
            end else begin
               state_in = olids_pkg::S_DONE;
            end
         end
         olids_pkg::S_SCAN_RD: begin
            cmd.raddr_sel = olids_pkg::RA_IDX;
            state_in      = olids_pkg::S_SCAN_CHK;
         end
         olids_pkg::S_SCAN_CHK: begin
            if (stat.mode == olids_pkg::MODE_READ) begin
               cmd.capture_read = 1'b1;
               state_in         = olids_pkg::S_DONE;
            end else if (stat.hit) begin
               cmd.set_status    = 1'b1;
               cmd.status        = olids_pkg::ST_OK;
               cmd.capture_found = 1'b1;
               state_in          = olids_pkg::S_DONE;
            end else begin
               cmd.idx_op = olids_pkg::IDX_INC;
               state_in   = olids_pkg::S_SCAN_LOOP;
            end
         end
         olids_pkg::S_DONE: begin
            if (stat.rsp_free) begin
               cmd.push_rsp = 1'b1;
               state_in     = olids_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = olids_pkg::S_IDLE;
         end
      endcase
   end

endmodule

### rtl/olids_dp.sv
// Datapath for the ordered list: item registers, index and count, entry
// RAM, result fields and output register. Depends on olids_pkg, olids_ram.
module olids_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [olids_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [olids_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  olids_pkg::ctrl_cmd_type           cmd,
   output olids_pkg::dp_stat_type            stat
);

   logic [olids_pkg::MODE_W-1:0]      mode_ff, mode_in;
   logic [olids_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [olids_pkg::DATA_W-1:0]      val_ff, val_in;
   logic [olids_pkg::DATA_W-1:0]      key_ff, key_in;
   logic [olids_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [olids_pkg::CNT_W-1:0]       idx_ff, idx_in;
   logic [olids_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [olids_pkg::FOUND_W-1:0]     res_found_ff, res_found_in;
   logic [olids_pkg::DATA_W-1:0]      res_read_ff, res_read_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [olids_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [olids_pkg::CMP_W-1:0]       pos_w, cnt_w, idx_w;
   logic [olids_pkg::CNT_W:0]         idx_plus_w, cnt_plus_w;
   logic [olids_pkg::CNT_W-1:0]       idx_prev, idx_next;
   logic [olids_pkg::ADDR_W-1:0]      ram_raddr, ram_waddr;
   logic [olids_pkg::DATA_W-1:0]      ram_wdata, ram_rdata;

   olids_ram #(
      .WIDTH (olids_pkg::DATA_W),
      .DEPTH (olids_pkg::DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (cmd.ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_read_ff   <= res_read_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign pos_w      = olids_pkg::CMP_W'(pos_ff);
   assign cnt_w      = olids_pkg::CMP_W'(count_ff);
   assign idx_w      = olids_pkg::CMP_W'(idx_ff);
   assign idx_plus_w = {1'b0, idx_ff} + 1'b1;
   assign cnt_plus_w = {1'b0, count_ff};
   assign idx_prev   = idx_ff - 1'b1;
   assign idx_next   = idx_ff + 1'b1;

   always_comb begin
      mode_in = mode_ff;
      pos_in  = pos_ff;
      val_in  = val_ff;
      key_in  = key_ff;
      if (cmd.load_item) begin
         mode_in = req_tdata[olids_pkg::REQ_MODE_LSB +: olids_pkg::MODE_W];
         pos_in  = req_tdata[olids_pkg::REQ_POS_LSB +: olids_pkg::POS_W];
         val_in  = req_tdata[olids_pkg::REQ_VAL_LSB +: olids_pkg::DATA_W];
         key_in  = req_tdata[olids_pkg::REQ_KEY_LSB +: olids_pkg::DATA_W];
      end
   end

   always_comb begin
      case (cmd.idx_op)
         olids_pkg::IDX_COUNT: idx_in = count_ff;
         olids_pkg::IDX_POS:   idx_in = pos_w[olids_pkg::CNT_W-1:0];
         olids_pkg::IDX_ZERO:  idx_in = '0;
         olids_pkg::IDX_INC:   idx_in = idx_next;
         olids_pkg::IDX_DEC:   idx_in = idx_prev;
         default:              idx_in = idx_ff;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         olids_pkg::CNT_CLEAR: count_in = '0;
         olids_pkg::CNT_INC:   count_in = count_ff + 1'b1;
         olids_pkg::CNT_DEC:   count_in = count_ff - 1'b1;
         default:              count_in = count_ff;
      endcase
   end

   always_comb begin
      case (cmd.raddr_sel)
         olids_pkg::RA_PREV: ram_raddr = idx_prev[olids_pkg::ADDR_W-1:0];
         olids_pkg::RA_NEXT: ram_raddr = idx_next[olids_pkg::ADDR_W-1:0];
         default:            ram_raddr = idx_ff[olids_pkg::ADDR_W-1:0];
      endcase
   end

   assign ram_waddr = idx_ff[olids_pkg::ADDR_W-1:0];
   assign ram_wdata = (cmd.wdata_sel == olids_pkg::WD_VALUE) ? val_ff : ram_rdata;

   always_comb begin
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_read_in   = res_read_ff;
      if (cmd.load_item) begin
         res_status_in = olids_pkg::ST_OK;
         res_found_in  = '0;
         res_read_in   = '0;
      end
      if (cmd.set_status) begin
         res_status_in = cmd.status;
      end
      if (cmd.capture_found) begin
         res_found_in = olids_pkg::FOUND_W'(idx_ff);
      end
      if (cmd.capture_read) begin
         res_read_in = ram_rdata;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.push_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = olids_pkg::RSP_DATA_W'({olids_pkg::COUNT_OUT_W'(count_ff),
                                                res_read_ff, res_found_ff,
                                                res_status_ff});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign stat.mode            = olids_pkg::mode_type'(mode_ff);
   assign stat.pos_gt_cnt      = pos_w > cnt_w;
   assign stat.pos_ge_cnt      = pos_w >= cnt_w;
   assign stat.cnt_full        = count_ff == olids_pkg::CNT_W'(olids_pkg::DEPTH);
   assign stat.idx_gt_pos      = idx_w > pos_w;
   assign stat.idx_next_lt_cnt = idx_plus_w < cnt_plus_w;
   assign stat.idx_lt_cnt      = idx_ff < count_ff;
   assign stat.hit             = ram_rdata == key_ff;
   assign stat.rsp_free        = !rsp_valid_ff || rsp_tready;

endmodule

### rtl/ordered_list_insert_delete_search.sv
// Top level of the ordered list with insert, delete, search and read.
// Depends on olids_pkg, olids_ctrl, olids_dp (which holds olids_ram).
//
//   channel   direction   fields (lowest bit first)
//   req_      in          mode[2:0] position[9:3] value[41:10] key[73:42]
//   rsp_      out         status[1:0] found_index[7:2] read_value[39:8]
//                         count_after[46:40]
//
// One item at a time. The entry RAM has one read and one write port with
// registered read data, so each moved or scanned entry passes through a
// loop state, a read state and a write state (a check state for scans).
// Synchronous reset empties the list; entries are not cleared.
// A new item is taken while an earlier result still waits in the output
// register; the result of that item waits until the register frees.
module ordered_list_insert_delete_search (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // mode, position, value, key; zero padding at the top
   input  logic [olids_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status, found_index, read_value, count_after; zero padding at the top
   output logic [olids_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   olids_pkg::ctrl_cmd_type cmd;
   olids_pkg::dp_stat_type  stat;

   olids_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   olids_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

### rtl/olids_chk.sv
// Port-level checker for the ordered list, bound to the top level.
// Depends on olids_pkg and ordered_list_insert_delete_search.
module olids_chk (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [olids_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [olids_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic [olids_pkg::STATUS_W-1:0]    rsp_status;
   logic [olids_pkg::FOUND_W-1:0]     rsp_found;
   logic [olids_pkg::DATA_W-1:0]      rsp_read;
   logic [olids_pkg::COUNT_OUT_W-1:0] rsp_count;

   assign rsp_status = rsp_tdata[olids_pkg::RSP_STATUS_LSB +: olids_pkg::STATUS_W];
   assign rsp_found  = rsp_tdata[olids_pkg::RSP_FOUND_LSB +: olids_pkg::FOUND_W];
   assign rsp_read   = rsp_tdata[olids_pkg::RSP_READ_LSB +: olids_pkg::DATA_W];
   assign rsp_count  = rsp_tdata[olids_pkg::RSP_COUNT_LSB +: olids_pkg::COUNT_OUT_W];

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_count <= olids_pkg::COUNT_OUT_W'(olids_pkg::DEPTH))
      else $error("count above list depth");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == olids_pkg::ST_FULL
      |-> rsp_count == olids_pkg::COUNT_OUT_W'(olids_pkg::DEPTH))
      else $error("full status with list not full");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_status == olids_pkg::ST_NOTFOUND
      |-> rsp_found == '0 && rsp_read == '0)
      else $error("missed search carries nonzero fields");

endmodule

bind ordered_list_insert_delete_search olids_chk u_olids_chk (.*);

### bench/olids_list_checker.sv
// Checker for the ordered list block: keeps its own copy of the list, predicts
// one response item per accepted request item and compares them in order.
// Depends on olids_pkg.
module olids_list_checker
   import olids_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    mismatches,
   output int                    pending,
   output int                    results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type             status;
      logic [FOUND_W-1:0]     found_index;
      logic [DATA_W-1:0]      read_value;
      logic [COUNT_OUT_W-1:0] count_after;
   } list_result_t;

   logic [DATA_W-1:0] list_entries [DEPTH];
   int                list_count;
   list_result_t      expected_results [$];

   function automatic list_result_t apply_list_op(input logic [MODE_W-1:0] mode,
                                                 input logic [POS_W-1:0]  pos,
                                                 input logic [DATA_W-1:0] value,
                                                 input logic [DATA_W-1:0] key);
      list_result_t r;
      int           p;
      p = int'(pos);
      r.status      = ST_OK;
      r.found_index = '0;
      r.read_value  = '0;
      case (mode)
         MODE_CLEAR: begin
            list_count = 0;
         end
         MODE_INSERT: begin
            if (p > list_count) begin
               r.status = ST_BADPOS;
            end else if (list_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (int i = list_count; i > p; i--) list_entries[i] = list_entries[i-1];
               list_entries[p] = value;
               list_count++;
            end
         end
         MODE_DELETE: begin
            if (p >= list_count) begin
               r.status = ST_BADPOS;
            end else begin
               for (int i = p; i + 1 < list_count; i++) list_entries[i] = list_entries[i+1];
               list_count--;
            end
         end
         MODE_SEARCH: begin
            r.status = ST_NOTFOUND;
            for (int i = 0; i < list_count && r.status == ST_NOTFOUND; i++) begin
               if (list_entries[i] == key) begin
                  r.status      = ST_OK;
                  r.found_index = FOUND_W'(i);
               end
            end
         end
         MODE_READ: begin
            if (p >= list_count) r.status = ST_BADPOS;
            else r.read_value = list_entries[p];
         end
         default: begin
         end
      endcase
      r.count_after = COUNT_OUT_W'(list_count);
      return r;
   endfunction

   always @(posedge clock) begin
      list_result_t want;
      list_result_t got;
      if (reset) begin
         list_count      = 0;
         mismatches      = 0;
         results_checked = 0;
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status      = status_type'(rsp_tdata[RSP_STATUS_LSB +: STATUS_W]);
            got.found_index = rsp_tdata[RSP_FOUND_LSB +: FOUND_W];
            got.read_value  = rsp_tdata[RSP_READ_LSB +: DATA_W];
            got.count_after = rsp_tdata[RSP_COUNT_LSB +: COUNT_OUT_W];
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: response item with none expected: status %0d count %0d",
                           $time, got.status, got.count_after);
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (got.status !== want.status || got.found_index !== want.found_index ||
                   got.read_value !== want.read_value ||
                   got.count_after !== want.count_after) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%t: result %0d (expected/actual) status %0d/%0d",
                               " found %0d/%0d read %h/%h count %0d/%0d"},
                              $time, results_checked, want.status, got.status,
                              want.found_index, got.found_index, want.read_value,
                              got.read_value, want.count_after, got.count_after);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_list_op(req_tdata[REQ_MODE_LSB +: MODE_W],
                                                     req_tdata[REQ_POS_LSB +: POS_W],
                                                     req_tdata[REQ_VAL_LSB +: DATA_W],
                                                     req_tdata[REQ_KEY_LSB +: DATA_W]));
      end
      pending = expected_results.size();
   end

endmodule

### bench/tb_ordered_list_insert_delete_search.sv
// Testbench top for the ordered list block: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict.
// Depends on olids_pkg, ordered_list_insert_delete_search and olids_list_checker.
module tb_ordered_list_insert_delete_search;
   timeunit 1ns;
   timeprecision 1ps;

   import olids_pkg::*;

   localparam int ITEM_TARGET     = 1950;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int TAIL_CYCLES     = 250;
   localparam int WATCHDOG_LIMIT  = 4000;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int                mismatches;
   int                pending;
   int                results_checked;
   int                shadow_count;
   int                burst_left;
   int                items_sent;
   int                fills;
   int                idle_cycles;
   int                mode_tally [8];
   bit                steady_sender;
   bit                hold_off_req;
   logic [DATA_W-1:0] last_value;

   ordered_list_insert_delete_search i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   olids_list_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatches      (mismatches),
      .pending         (pending),
      .results_checked (results_checked)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("ordered_list_insert_delete_search verification failed");
            $finish;
         end
      end
   end

   function automatic logic [DATA_W-1:0] list_value();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return DATA_W'($urandom_range(0, 7)) - DATA_W'(4);
      if (r == 4) begin
         case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '1;
            default: return '0;
         endcase
      end
      return $urandom;
   endfunction

   // last_ok is the highest legal position, -1 when none is legal
   function automatic int list_pos(input int last_ok);
      int r;
      r = $urandom_range(0, 99);
      if (last_ok < 0 || r < 10) return $urandom_range(last_ok + 1, 127);
      if (r < 35) return last_ok;
      if (r < 50) return 0;
      return $urandom_range(0, last_ok);
   endfunction

   task automatic send_item(input logic [MODE_W-1:0] mode, input int pos,
                            input logic [DATA_W-1:0] value, input logic [DATA_W-1:0] key);
      int gap;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = REQ_DATA_W'({key, value, POS_W'(pos), mode});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      mode_tally[mode]++;
      case (mode)
         MODE_CLEAR: shadow_count = 0;
         MODE_INSERT: begin
            if (pos <= shadow_count && shadow_count < DEPTH) begin
               shadow_count++;
               if (shadow_count == DEPTH) fills++;
            end
         end
         MODE_DELETE: if (pos < shadow_count) shadow_count--;
         default: begin
         end
      endcase
      if (!steady_sender) begin
         burst_left--;
         if (burst_left <= 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
            @(negedge clock);
            req_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clock);
            burst_left = $urandom_range(1, 24);
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // receiver: changing stall patterns, plus one long hold-off on request
   initial begin
      int style;
      int style_left;
      int phase;
      int period;
      bit hold_served;
      style       = 0;
      style_left  = 0;
      phase       = 0;
      period      = 2;
      hold_served = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_served) begin
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_served = 1'b1;
         end else begin
            if (style_left == 0) begin
               style      = $urandom_range(0, 3);
               style_left = $urandom_range(20, 300);
               period     = $urandom_range(2, 6);
            end
            style_left--;
            phase = (phase + 1) % period;
            case (style)
               0:       rsp_tready = 1'b1;
               1:       rsp_tready = 1'($urandom_range(0, 1));
               2:       rsp_tready = (phase == 0);
               default: rsp_tready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      int  r;
      int  n;
      int  ins_w;
      int  del_w;
      bit  hold_done;
      bit  drain_done;
      logic [DATA_W-1:0] v;
      hold_done     = 1'b0;
      drain_done    = 1'b0;
      shadow_count  = 0;
      items_sent    = 0;
      fills         = 0;
      steady_sender = 1'b1;
      hold_off_req  = 1'b0;
      burst_left    = $urandom_range(1, 24);
      last_value    = '0;
      foreach (mode_tally[i]) mode_tally[i] = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_item(MODE_SEARCH, 0, '0, '0);
      send_item(MODE_READ, 0, '0, '0);
      send_item(MODE_DELETE, 0, '0, '0);
      send_item(MODE_INSERT, 1, 32'h1111_1111, '0);
      send_item(MODE_INSERT, 0, 32'h8000_0000, '0);
      send_item(MODE_INSERT, 1, 32'h7FFF_FFFF, '0);
      send_item(MODE_INSERT, 0, '0, '0);
      send_item(MODE_INSERT, 2, '1, '0);
      send_item(MODE_INSERT, 4, '0, '0);
      send_item(MODE_SEARCH, 0, '0, '0);
      send_item(MODE_SEARCH, 0, '0, 32'h7FFF_FFFF);
      send_item(MODE_SEARCH, 0, '0, 32'd1234);
      send_item(MODE_READ, 0, '0, '0);
      send_item(MODE_READ, 4, '0, '0);
      send_item(MODE_READ, 5, '0, '0);
      send_item(MODE_INSERT, 6, 32'h2222_2222, '0);
      send_item(MODE_DELETE, 127, '0, '0);
      send_item(MODE_DELETE, 4, '0, '0);
      send_item(MODE_DELETE, 0, '0, '0);
      send_item(MODE_DELETE, 1, '0, '0);
      send_item(3'd5, 127, '1, '1);
      send_item(3'd6, 127, '1, '1);
      send_item(3'd7, 127, '1, '1);
      send_item(MODE_CLEAR, 127, '1, '1);
      send_item(MODE_READ, 0, '0, '0);
      wait_drained();
      steady_sender = 1'b0;

      while (items_sent < ITEM_TARGET) begin
         if (!hold_done && items_sent >= 700) begin
            hold_off_req = 1'b1;
            hold_done    = 1'b1;
         end
         if (!drain_done && items_sent >= 1300) begin
            wait_drained();
            drain_done = 1'b1;
         end
         if ($urandom_range(0, 99) == 0) steady_sender = !steady_sender;
         r = $urandom_range(0, 99);
         if (r < 6) begin
            send_item(MODE_CLEAR, $urandom_range(0, 127), $urandom, $urandom);
            r = $urandom_range(0, 99);
            n = (r < 70) ? $urandom_range(1, 10) : (r < 90) ? $urandom_range(11, 30) : DEPTH;
            repeat (n) begin
               v          = list_value();
               last_value = v;
               send_item(MODE_INSERT, shadow_count, v, $urandom);
            end
            if (n == DEPTH) begin
               send_item(MODE_INSERT, $urandom_range(0, DEPTH), list_value(), $urandom);
               send_item(MODE_INSERT, $urandom_range(DEPTH + 1, 127), list_value(), $urandom);
               send_item(MODE_SEARCH, $urandom_range(0, 127), $urandom, last_value);
               send_item(MODE_READ, DEPTH - 1, $urandom, $urandom);
               send_item(MODE_DELETE, $urandom_range(0, DEPTH - 1), $urandom, $urandom);
            end
         end else if (r < 9) begin
            send_item(MODE_CLEAR, $urandom_range(0, 127), $urandom, $urandom);
         end else if (r < 12) begin
            send_item(MODE_W'($urandom_range(5, 7)), $urandom_range(0, 127), $urandom, $urandom);
         end else begin
            ins_w = (shadow_count > 24) ? 15 : 35;
            del_w = (shadow_count > 24) ? 40 : 20;
            r     = $urandom_range(0, 99);
            if (r < ins_w) begin
               v          = list_value();
               last_value = v;
               send_item(MODE_INSERT, list_pos(shadow_count), v, $urandom);
            end else if (r < ins_w + del_w) begin
               send_item(MODE_DELETE, list_pos(shadow_count - 1), $urandom, $urandom);
            end else if (r < ins_w + del_w + 25) begin
               v = ($urandom_range(0, 99) < 35) ? last_value : list_value();
               send_item(MODE_SEARCH, $urandom_range(0, 127), $urandom, v);
            end else begin
               send_item(MODE_READ, list_pos(shadow_count - 1), $urandom, $urandom);
            end
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("%0d items sent: %0d clear, %0d insert, %0d delete, %0d search, %0d read",
               items_sent, mode_tally[MODE_CLEAR], mode_tally[MODE_INSERT],
               mode_tally[MODE_DELETE], mode_tally[MODE_SEARCH], mode_tally[MODE_READ]);
      $display("%0d unused mode items, list filled %0d times, %0d results compared",
               mode_tally[5] + mode_tally[6] + mode_tally[7], fills, results_checked);
      if (mismatches == 0 && pending == 0) begin
         $display("ordered_list_insert_delete_search verification clean");
      end else begin
         if (pending != 0) $display("%0d expected results never arrived", pending);
         $display("ordered_list_insert_delete_search verification failed");
      end
      $finish;
   end

endmodule
